>>> rtl/core/pte_pkg.sv
// Shared types and codes for the process table engine.
`default_nettype none
package pte_pkg;
   typedef enum logic [2:0] {
      ACT_ADD = 3'd0, ACT_REMOVE = 3'd1, ACT_LIST_ALL = 3'd2,
      ACT_LIST_READY = 3'd3, ACT_LIST_MAX = 3'd4
   } action_type;

   localparam logic [1:0] CODE_OK      = 2'd0;
   localparam logic [1:0] CODE_FULL    = 2'd1;
   localparam logic [1:0] CODE_NOTFND  = 2'd2;
   localparam logic [1:0] CODE_NOTHING = 2'd3;

   localparam logic [1:0] ST_READY = 2'd0;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] proc_id;
      logic [1:0]  proc_state;
      logic [7:0]  proc_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]  code;
      logic [15:0] out_id;
      logic [1:0]  out_state;
      logic [7:0]  out_priority;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

>>> rtl/core/pte_front.sv
// Front end: accepts requests, drops unknown actions, two-entry queue.
`default_nettype none
module pte_front
   import pte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         q_valid,
   input  wire logic    q_pop,
   output req_type      q_data
);
   req_type    slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       push, known;

   assign known     = req_data.action <= ACT_LIST_MAX;
   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall && known;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_data    = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
      rd_in  = rd_ff ^ (q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) slot_ff[rd_ff ^ cnt_ff[0]] <= req_data;
   end
endmodule
`default_nettype wire

>>> rtl/core/pte_back.sv
// Back end: table storage, scan/shift sequencer and result register.
`default_nettype none
module pte_back
   import pte_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   output logic         q_pop,
   input  wire req_type q_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_FIND = 6'b000010, S_SHIFT = 6'b000100,
      S_MAX  = 6'b001000, S_LIST = 6'b010000, S_OUT  = 6'b100000
   } state_type;

   logic [15:0] id_ff  [MAX_ENTRIES];
   logic [1:0]  st_ff  [MAX_ENTRIES];
   logic [7:0]  pr_ff  [MAX_ENTRIES];
   state_type   state_ff;
   logic [CW-1:0] count_ff, idx_ff;
   logic [7:0]  best_ff;
   logic        found_ff;
   req_type     cur_ff;
   rsp_type     out_ff;
   logic        ov_ff;
   // held-back entry: emitted once the next match (or end) is known
   rsp_type     pend_ff;
   logic        pend_v_ff;

   logic [IW-1:0] ix;
   logic          at_end, match, out_free;

   assign ix        = idx_ff[IW-1:0];
   assign at_end    = idx_ff == count_ff;
   assign out_free  = !ov_ff || !rsp_stall;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
   assign q_pop     = state_ff == S_IDLE && q_valid;

   always_comb begin
      match = 1'b0;
      case (action_type'(cur_ff.action))
         ACT_LIST_READY: match = st_ff[ix] == ST_READY;
         ACT_LIST_MAX:   match = pr_ff[ix] == best_ff;
         default:        match = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ov_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (q_valid) begin
               cur_ff    <= q_data;
               idx_ff    <= '0;
               best_ff   <= '0;
               found_ff  <= 1'b0;
               pend_v_ff <= 1'b0;
               case (action_type'(q_data.action))
                  ACT_ADD:    state_ff <= S_OUT;
                  ACT_REMOVE: state_ff <= S_FIND;
                  ACT_LIST_MAX: state_ff <= S_MAX;
                  default:    state_ff <= S_LIST;
               endcase
            end
            S_FIND: begin
               if (at_end) state_ff <= S_OUT;
               else if (id_ff[ix] == cur_ff.proc_id) begin
                  found_ff <= 1'b1;
                  state_ff <= S_SHIFT;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_SHIFT: begin
               if (idx_ff + 1'b1 >= count_ff) begin
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  id_ff[ix] <= id_ff[ix + 1'b1];
                  st_ff[ix] <= st_ff[ix + 1'b1];
                  pr_ff[ix] <= pr_ff[ix + 1'b1];
                  idx_ff    <= idx_ff + 1'b1;
               end
            end
            S_MAX: begin
               if (at_end) begin
                  idx_ff   <= '0;
                  state_ff <= S_LIST;
               end else begin
                  if (pr_ff[ix] > best_ff) best_ff <= pr_ff[ix];
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_LIST: if (out_free) begin
               if (at_end) begin
                  ov_ff <= 1'b1;
                  if (pend_v_ff) out_ff <= '{pend_ff.code, pend_ff.out_id,
                     pend_ff.out_state, pend_ff.out_priority, 1'b1};
                  else out_ff <= '{CODE_NOTHING, 16'd0, 2'd0, 8'd0, 1'b1};
                  state_ff <= S_IDLE;
               end else begin
                  if (match) begin
                     if (pend_v_ff) begin
                        out_ff <= pend_ff;
                        ov_ff  <= 1'b1;
                     end
                     pend_ff   <= '{CODE_OK, id_ff[ix], st_ff[ix], pr_ff[ix], 1'b0};
                     pend_v_ff <= 1'b1;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_OUT: if (out_free) begin
               ov_ff    <= 1'b1;
               state_ff <= S_IDLE;
               out_ff   <= '{CODE_OK, 16'd0, 2'd0, 8'd0, 1'b1};
               if (action_type'(cur_ff.action) == ACT_ADD) begin
                  if (count_ff == CW'(MAX_ENTRIES)) out_ff.code <= CODE_FULL;
                  else if (cur_ff.proc_state > ST_WAIT) out_ff.code <= CODE_NOTFND;
                  else begin
                     id_ff[count_ff[IW-1:0]] <= cur_ff.proc_id;
                     st_ff[count_ff[IW-1:0]] <= cur_ff.proc_state;
                     pr_ff[count_ff[IW-1:0]] <= cur_ff.proc_priority;
                     count_ff <= count_ff + 1'b1;
                  end
               end else if (count_ff == '0 && !found_ff) out_ff.code <= CODE_NOTHING;
               else if (!found_ff) out_ff.code <= CODE_NOTFND;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> rtl/core/process_table_engine.sv
// Top level of the process table engine.
// The back end handles one request at a time and takes the next only once it is done;
// it scans the table one entry per cycle, and the list scan waits while a result is stalled.
// Front queue holds two requests so the input side keeps moving.
// Reset: synchronous, empties the table and queue; table storage itself is not cleared.
`default_nettype none
module process_table_engine
   import pte_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   logic    q_valid, q_pop;
   req_type q_data;

   // front: accept and filter, queue toward back end
   pte_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_pop, .q_data
   );

   // back: table ops and result transfers
   pte_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   // queue never pops empty
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop of empty queue");
endmodule
`default_nettype wire

>>> test/process_table_engine_test.sv
// Self-checking testbench for the process table engine.
`timescale 1ns / 1ps
module process_table_engine_test;
   import pte_pkg::*;

   localparam int TABLE_DEPTH = 16;

   // Tracks the table contents and holds the results each request should produce.
   class table_scoreboard;
      logic [15:0] ids[$];
      logic [1:0]  states[$];
      logic [7:0]  prios[$];
      rsp_type     pending[$];
      int          mismatches;

      function void push(logic [1:0] code, logic [15:0] id, logic [1:0] st,
                         logic [7:0] pr, logic lst);
         rsp_type r;
         r.code = code; r.out_id = id; r.out_state = st;
         r.out_priority = pr; r.last = lst;
         pending.push_back(r);
      endfunction

      // Close a list: mark its last result, or add one "nothing" result for an empty list.
      function void close_list(int n);
         rsp_type r;
         if (n == 0) push(CODE_NOTHING, '0, '0, '0, 1'b1);
         else begin
            r = pending.pop_back();
            r.last = 1'b1;
            pending.push_back(r);
         end
      endfunction

      function void note_request(req_type q);
         int hit;
         int n;
         logic [7:0] best;
         n = 0;
         best = '0;
         hit = -1;
         case (q.action)
            ACT_ADD: begin
               if (ids.size() >= TABLE_DEPTH) push(CODE_FULL, '0, '0, '0, 1'b1);
               else if (q.proc_state > ST_WAIT) push(CODE_NOTFND, '0, '0, '0, 1'b1);
               else begin
                  ids.push_back(q.proc_id);
                  states.push_back(q.proc_state);
                  prios.push_back(q.proc_priority);
                  push(CODE_OK, '0, '0, '0, 1'b1);
               end
            end
            ACT_REMOVE: begin
               if (ids.size() == 0) push(CODE_NOTHING, '0, '0, '0, 1'b1);
               else begin
                  foreach (ids[i]) if (hit < 0 && ids[i] == q.proc_id) hit = i;
                  if (hit < 0) push(CODE_NOTFND, '0, '0, '0, 1'b1);
                  else begin
                     ids.delete(hit); states.delete(hit); prios.delete(hit);
                     push(CODE_OK, '0, '0, '0, 1'b1);
                  end
               end
            end
            ACT_LIST_ALL: begin
               foreach (ids[i]) begin
                  push(CODE_OK, ids[i], states[i], prios[i], 1'b0);
                  n++;
               end
               close_list(n);
            end
            ACT_LIST_READY: begin
               foreach (ids[i]) if (states[i] == ST_READY) begin
                  push(CODE_OK, ids[i], states[i], prios[i], 1'b0);
                  n++;
               end
               close_list(n);
            end
            ACT_LIST_MAX: begin
               foreach (prios[i]) if (prios[i] > best) best = prios[i];
               foreach (prios[i]) if (prios[i] == best) begin
                  push(CODE_OK, ids[i], states[i], prios[i], 1'b0);
                  n++;
               end
               close_list(n);
            end
            default: ;  // undefined actions are dropped silently
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", want, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   table_scoreboard board = new();
   bit      quiet = 0;   // no idle bursts or result stalls in the final stretch

   process_table_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Result side: check every transfer, stall in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   initial begin : result_stall
      int k;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1;
            k = $urandom_range(1, 9);
            repeat (k) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // One request transfer; an optional idle burst goes in first.
   task automatic send(req_type q);
      int k;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         k = $urandom_range(1, 9);
         repeat (k) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
   endtask

   task automatic send_fields(logic [2:0] a, logic [15:0] id, logic [1:0] st,
                              logic [7:0] pr);
      req_type q;
      q.action = a; q.proc_id = id; q.proc_state = st; q.proc_priority = pr;
      send(q);
   endtask

   function automatic logic [15:0] pick_id();
      int n;
      n = board.ids.size();
      if (n > 0 && $urandom_range(0, 2) != 0) return board.ids[$urandom_range(0, n - 1)];
      if ($urandom_range(0, 1)) return 16'($urandom_range(0, 7));
      return 16'($urandom);
   endfunction

   initial begin : stimulus
      int r;
      logic [2:0] a;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty-table cases first.
      send_fields(ACT_LIST_ALL, '0, '0, '0);
      send_fields(ACT_LIST_READY, '0, '0, '0);
      send_fields(ACT_LIST_MAX, '0, '0, '0);
      send_fields(ACT_REMOVE, 16'hFFFF, '0, '0);
      send_fields(ACT_ADD, 16'hFFFF, 2'd3, 8'hFF);      // bad status rejected
      send_fields(ACT_ADD, 16'h0000, ST_WAIT, 8'h00);
      send_fields(ACT_LIST_MAX, '0, '0, '0);            // all at priority zero
      send_fields(ACT_LIST_READY, '0, '0, '0);          // no ready entry
      send_fields(ACT_ADD, 16'hFFFF, ST_READY, 8'hFF);
      send_fields(ACT_ADD, 16'hFFFF, 2'd1, 8'hFF);      // duplicate id, tie
      send_fields(ACT_LIST_MAX, '0, '0, '0);
      send_fields(ACT_REMOVE, 16'h1234, '0, '0);        // not present
      send_fields(ACT_REMOVE, 16'hFFFF, '0, '0);        // first match goes
      send_fields(ACT_LIST_ALL, '0, '0, '0);
      send_fields(3'd5, '0, '0, '0);
      send_fields(3'd7, 16'hFFFF, 2'd3, 8'hFF);
      // Fill past full.
      for (int i = 0; i < 15; i++)
         send_fields(ACT_ADD, 16'(16'h100 + i), 2'(i % 3), 8'(i * 17));
      send_fields(ACT_ADD, 16'hAAAA, ST_READY, 8'h55);
      send_fields(ACT_LIST_ALL, '0, '0, '0);
      send_fields(ACT_REMOVE, 16'h0000, '0, '0);

      // Random: biased toward existing ids and a table that fills and drains.
      for (int i = 0; i < 300; i++) begin
         if (i == 240) quiet = 1;
         r = $urandom_range(0, 99);
         if (r < 35) a = ACT_ADD;
         else if (r < 65) a = ACT_REMOVE;
         else if (r < 75) a = ACT_LIST_ALL;
         else if (r < 85) a = ACT_LIST_READY;
         else if (r < 95) a = ACT_LIST_MAX;
         else a = 3'($urandom_range(5, 7));
         send_fields(a, pick_id(),
                     ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255))
                                                 : 8'($urandom));
      end
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.mismatches == 0) $display("process_table_engine: match");
      else $display("process_table_engine: mismatch");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("process_table_engine: mismatch");
      $finish;
   end
endmodule

>>> files.f
rtl/core/pte_pkg.sv
rtl/core/pte_front.sv
rtl/core/pte_back.sv
rtl/core/process_table_engine.sv
test/process_table_engine_test.sv
